FILE: rtl/xcr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared constants, codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package xcr_pkg;

	localparam int PAYLOAD_BYTES = 128;
	localparam int PACKET_BYTES  = 132;
	localparam int WORD_COUNT    = PAYLOAD_BYTES / 4;
	localparam int WORD_IDX_W    = $clog2(WORD_COUNT);
	localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);

	// Byte index of the checksum byte, the final byte of a packet.
	localparam logic [7:0] SUM_BYTE_IDX = 8'(PACKET_BYTES - 1);
	localparam logic [7:0] HDR_BYTES    = 8'd3;
	localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = WORD_IDX_W'(WORD_COUNT - 1);

	// Command codes on the input channel.
	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_BYTE    = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	// Control characters.
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_NONE = 8'h00;
	localparam logic [7:0] SEQ_PAIR_SUM = 8'hFF;

	// Transfer phases.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RECV = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_PROGRESS     = 3'd0;
	localparam logic [2:0] ST_ACCEPTED     = 3'd1;
	localparam logic [2:0] ST_COMPLETED    = 3'd2;
	localparam logic [2:0] ST_TIMEOUT_FAIL = 3'd3;
	localparam logic [2:0] ST_SEQ_FAIL     = 3'd4;
	localparam logic [2:0] ST_SUM_FAIL     = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_BASE_ADDRESS = 1'b0;
	localparam logic CFG_RETRY_LIMIT  = 1'b1;

	localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;

	typedef struct packed {
		logic                  accept;
		logic                  rd_en;
		logic                  load_word;
		logic [WORD_IDX_W-1:0] word_idx;
	} xcr_cmd_t;

	typedef struct packed {
		logic good_pkt;
		logic out_free;
	} xcr_sts_t;

endpackage

FILE: rtl/xcr_ctrl.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver controller
// Accepts input beats and sequences the read-out of a good packet as flash
// words, one memory read and one output load per word.
// ----------------------------------------------------------------------------
module xcr_ctrl
	import xcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  xcr_sts_t sts,
	output xcr_cmd_t ctl
);

	localparam logic [1:0] CS_IDLE = 2'd0;
	localparam logic [1:0] CS_READ = 2'd1;
	localparam logic [1:0] CS_LOAD = 2'd2;

	logic [1:0]            state_q;
	logic [WORD_IDX_W-1:0] word_idx_q;

	assign in_stall      = (state_q != CS_IDLE) || !sts.out_free;
	assign ctl.accept    = in_valid && !in_stall;
	assign ctl.rd_en     = (state_q == CS_READ);
	assign ctl.load_word = (state_q == CS_LOAD) && sts.out_free;
	assign ctl.word_idx  = word_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_IDLE;
			word_idx_q <= '0;
		end else begin
			case (state_q)
				CS_IDLE: begin
					if (ctl.accept && sts.good_pkt) begin
						state_q    <= CS_READ;
						word_idx_q <= '0;
					end
				end
				CS_READ: begin
					state_q <= CS_LOAD;
				end
				CS_LOAD: begin
					if (sts.out_free) begin
						if (word_idx_q == LAST_WORD_IDX) begin
							state_q <= CS_IDLE;
						end else begin
							state_q    <= CS_READ;
							word_idx_q <= word_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_good_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && sts.good_pkt |=> state_q == CS_READ)
		else $error("good packet did not start the word read-out");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != CS_IDLE |-> !ctl.accept)
		else $error("input accepted during word read-out");

	a_last_word_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_word && ctl.word_idx == LAST_WORD_IDX |=> state_q == CS_IDLE)
		else $error("read-out did not end after the last word");
`endif

endmodule

FILE: rtl/xcr_dp.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver datapath
// Protocol state, packet checks, payload memory and the output register.
// ----------------------------------------------------------------------------
module xcr_dp
	import xcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_data,
	input  xcr_cmd_t    ctl,
	output xcr_sts_t    sts,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic        write_valid,
	output logic [31:0] write_address,
	output logic [31:0] write_word,
	output logic [2:0]  status,
	output logic        last
);

	logic [31:0] base_q;
	logic [7:0]  limit_q;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  retries_q, retries_d;
	logic        seen_q, seen_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  comp_q, comp_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] next_addr_q, next_addr_d;

	logic [3:0][7:0] mem_q [WORD_COUNT];
	logic [31:0]     rd_word_q;
	logic [31:0]     wr_addr_q;
	logic [PAYLOAD_IDX_W-1:0] mem_idx;

	logic       res_valid, res_reply_valid, mem_we, good, do_fail;
	logic [7:0] res_reply_byte;
	logic [2:0] res_status, fail_status;
	logic       hdr_ok, load_single;

	logic        out_valid_q, reply_valid_q, write_valid_q, last_q;
	logic [7:0]  reply_byte_q;
	logic [31:0] write_address_q, write_word_q;
	logic [2:0]  status_q;

	assign mem_idx = PAYLOAD_IDX_W'(cnt_q - HDR_BYTES);
	assign hdr_ok  = (hdr_q == CH_SOH) && (8'(seq_q + comp_q) == SEQ_PAIR_SUM);

	always_comb begin
		phase_d        = phase_q;
		cnt_d          = cnt_q;
		exp_d          = exp_q;
		retries_d      = retries_q;
		seen_d         = seen_q;
		hdr_d          = hdr_q;
		seq_d          = seq_q;
		comp_d         = comp_q;
		sum_d          = sum_q;
		next_addr_d    = next_addr_q;
		res_valid      = 1'b0;
		res_reply_valid = 1'b0;
		res_reply_byte = CH_NONE;
		res_status     = ST_PROGRESS;
		do_fail        = 1'b0;
		fail_status    = ST_PROGRESS;
		mem_we         = 1'b0;
		good           = 1'b0;

		if (cmd == CMD_START) begin
			phase_d         = PH_RECV;
			exp_d           = 8'd1;
			next_addr_d     = base_q;
			retries_d       = limit_q;
			seen_d          = 1'b0;
			cnt_d           = '0;
			sum_d           = '0;
			res_valid       = 1'b1;
			res_reply_valid = 1'b1;
			res_reply_byte  = CH_NAK;
		end else if (phase_q == PH_RECV) begin
			case (cmd)
				CMD_TIMEOUT: begin
					if (!seen_q) begin
						cnt_d           = '0;
						sum_d           = '0;
						res_valid       = 1'b1;
						res_reply_valid = 1'b1;
						res_reply_byte  = CH_NAK;
					end else begin
						do_fail     = 1'b1;
						fail_status = ST_TIMEOUT_FAIL;
					end
				end
				CMD_BYTE: begin
					if (cnt_q == 8'd0) begin
						if (rx_data == CH_EOT) begin
							phase_d         = PH_DONE;
							res_valid       = 1'b1;
							res_reply_valid = 1'b1;
							res_reply_byte  = CH_ACK;
							res_status      = ST_COMPLETED;
						end else begin
							seen_d = 1'b1;
							hdr_d  = rx_data;
							sum_d  = '0;
							cnt_d  = 8'd1;
						end
					end else if (cnt_q == 8'd1) begin
						seq_d = rx_data;
						cnt_d = 8'd2;
					end else if (cnt_q == 8'd2) begin
						comp_d = rx_data;
						cnt_d  = HDR_BYTES;
					end else if (cnt_q < SUM_BYTE_IDX) begin
						mem_we = 1'b1;
						sum_d  = sum_q + rx_data;
						cnt_d  = cnt_q + 8'd1;
					end else begin
						if (!hdr_ok) begin
							do_fail     = 1'b1;
							fail_status = ST_SEQ_FAIL;
						end else if (seq_q == 8'(exp_q - 8'd1)) begin
							// Duplicate of the last packet: acknowledge, write nothing.
							cnt_d           = '0;
							sum_d           = '0;
							res_valid       = 1'b1;
							res_reply_valid = 1'b1;
							res_reply_byte  = CH_ACK;
						end else if (seq_q != exp_q) begin
							do_fail     = 1'b1;
							fail_status = ST_SEQ_FAIL;
						end else if (sum_q != rx_data) begin
							do_fail     = 1'b1;
							fail_status = ST_SUM_FAIL;
						end else begin
							good = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (do_fail) begin
			cnt_d     = '0;
			sum_d     = '0;
			res_valid = 1'b1;
			if (retries_q <= 8'd1) begin
				retries_d  = '0;
				phase_d    = PH_DONE;
				res_status = fail_status;
			end else begin
				retries_d       = retries_q - 8'd1;
				res_reply_valid = 1'b1;
				res_reply_byte  = CH_NAK;
			end
		end

		if (good) begin
			next_addr_d = next_addr_q + 32'(PAYLOAD_BYTES);
			exp_d       = exp_q + 8'd1;
			retries_d   = limit_q;
			seen_d      = 1'b0;
			cnt_d       = '0;
			sum_d       = '0;
		end
	end

	assign sts.good_pkt = good;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign load_single  = ctl.accept && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= RETRY_LIMIT_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_BASE_ADDRESS: base_q  <= cfg_data;
				CFG_RETRY_LIMIT:  limit_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			exp_q       <= 8'd1;
			retries_q   <= '0;
			seen_q      <= 1'b0;
			hdr_q       <= '0;
			seq_q       <= '0;
			comp_q      <= '0;
			sum_q       <= '0;
			next_addr_q <= '0;
		end else if (ctl.accept) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			exp_q       <= exp_d;
			retries_q   <= retries_d;
			seen_q      <= seen_d;
			hdr_q       <= hdr_d;
			seq_q       <= seq_d;
			comp_q      <= comp_d;
			sum_q       <= sum_d;
			next_addr_q <= next_addr_d;
		end
	end

	// Payload memory: byte lanes, little-endian within each word.
	always_ff @(posedge clk) begin
		if (ctl.accept && mem_we) begin
			mem_q[mem_idx[PAYLOAD_IDX_W-1:2]][mem_idx[1:0]] <= rx_data;
		end
		if (ctl.rd_en) begin
			rd_word_q <= mem_q[ctl.word_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && good) begin
			wr_addr_q <= next_addr_q;
		end else if (ctl.load_word) begin
			wr_addr_q <= wr_addr_q + 32'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || ctl.load_word) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			reply_valid_q   <= res_reply_valid;
			reply_byte_q    <= res_reply_byte;
			write_valid_q   <= 1'b0;
			write_address_q <= '0;
			write_word_q    <= '0;
			status_q        <= res_status;
			last_q          <= 1'b1;
		end else if (ctl.load_word) begin
			reply_valid_q   <= (ctl.word_idx == LAST_WORD_IDX);
			reply_byte_q    <= (ctl.word_idx == LAST_WORD_IDX) ? CH_ACK : CH_NONE;
			write_valid_q   <= 1'b1;
			write_address_q <= wr_addr_q;
			write_word_q    <= rd_word_q;
			status_q        <= ST_ACCEPTED;
			last_q          <= (ctl.word_idx == LAST_WORD_IDX);
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_valid   = reply_valid_q;
	assign reply_byte    = reply_byte_q;
	assign write_valid   = write_valid_q;
	assign write_address = write_address_q;
	assign write_word    = write_word_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule

FILE: rtl/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Receives 132-byte checksum packets and turns good ones into flash writes.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one beat per event:
// a start command, a received serial byte or a read timeout. The output
// channel (out_valid/out_stall) carries results: a reply byte (ACK or NAK)
// for the transmitter, a flash word to program, or both, with a status code
// and a last flag on the final result caused by one input beat.
// A start, a timeout, an EOT and any error answer with one result, loaded
// into the output register at the edge that accepts the beat. Bytes inside a
// packet give no result. The checksum byte of a good packet starts a
// read-out of the payload memory: 32 words, each a memory read followed by
// an output load, with ACK riding on the last word. No input is accepted
// during the read-out.
// When the receiver stalls, the output register holds its beat; in_stall
// rises while a result waits and is stalled, so a stall downstream holds
// back the input channel. Reset empties the output register, puts the
// transfer in idle, sets base_address to 0 and retry_limit to 10. The
// payload memory needs no clearing: it is always written before it is read.
// Configuration writes land at once; base_address is used at the next start.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver
	import xcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_data,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic        write_valid,
	output logic [31:0] write_address,
	output logic [31:0] write_word,
	output logic [2:0]  status,
	output logic        last
);

	// Commands from the controller and status from the datapath.
	xcr_cmd_t ctl;
	xcr_sts_t sts;

	xcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	xcr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.rx_data       (rx_data),
		.ctl           (ctl),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.reply_valid   (reply_valid),
		.reply_byte    (reply_byte),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_word    (write_word),
		.status        (status),
		.last          (last)
	);

endmodule

FILE: test/tb_xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// Testbench for the XMODEM checksum receiver
// A short table of directed rows walks the command corner cases: ignored
// events, timeouts before and after the first byte, a good packet whose
// flash addresses wrap, retry exhaustion, end of transfer and a restart in
// the middle of a packet. Short random steps follow under four idling
// profiles. Every result beat is compared field by field against a
// cycle-free predictor of the receiver that runs as each input beat is
// accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xmodem_checksum_receiver;
	import xcr_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 10;
	// Idle cycles before a register write: a byte inside a packet gives no
	// result, so the block may still be busy with it after the queue drains.
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	// Least number of input beats sent in each random phase.
	localparam int PHASE_ITEMS    = 10;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// One result beat as the receiver presents it.
	typedef struct packed {
		logic        reply_v;
		logic [7:0]  reply_b;
		logic        wr_v;
		logic [31:0] wr_addr;
		logic [31:0] wr_word;
		logic [2:0]  stat;
		logic        lst;
	} xfer_result_t;

	// How the expectation of a directed beat is obtained: from the predictor,
	// or typed in because it is obvious (nothing, a NAK, the final ACK).
	typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_NAK, EXP_DONE} exp_how_t;
	typedef enum logic [1:0] {ROW_BEAT, ROW_PACKET, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {FL_NONE, FL_HEADER, FL_COMPL, FL_SUM} flaw_t;
	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  c;
		logic [7:0]  d;
		exp_how_t    how;
		logic [7:0]  seq;
		flaw_t       flaw;
		fill_t       fill;
		logic [7:0]  nbytes;
		logic        reg_idx;
		logic [31:0] reg_val;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_START;
	logic [7:0]  rx_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reply_valid;
	logic [7:0]  reply_byte;
	logic        write_valid;
	logic [31:0] write_address;
	logic [31:0] write_word;
	logic [2:0]  status;
	logic        last;

	xmodem_checksum_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.rx_data       (rx_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reply_valid   (reply_valid),
		.reply_byte    (reply_byte),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_word    (write_word),
		.status        (status),
		.last          (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// Idling profile of the current phase, in percent of cycles.
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int phase_items = 0;
	int quiet_cycles = 0;

	xfer_result_t awaited_results[$];
	xfer_result_t step_results[$];
	plan_row_t    plan[$];

	// Predictor state and its copy of the registers.
	logic [1:0]  p_phase;
	logic [7:0]  p_count;
	logic [7:0]  p_expect_seq;
	logic [7:0]  p_retries;
	logic        p_seen;
	logic [7:0]  p_hdr;
	logic [7:0]  p_seq;
	logic [7:0]  p_cpl;
	logic [7:0]  p_sum;
	logic [7:0]  p_payload [PAYLOAD_BYTES];
	logic [31:0] p_next_addr;
	logic [31:0] c_base;
	logic [7:0]  c_retry;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic void put_result(input logic rv, input logic [7:0] rb,
			input logic wv, input logic [31:0] wa, input logic [31:0] ww,
			input logic [2:0] st, input logic lst);
		step_results.push_back(xfer_result_t'{rv, rb, wv, wa, ww, st, lst});
	endfunction

	// An error or a timeout after the first byte throws the partial packet
	// away and costs one retry. The last retry fails the transfer with no
	// reply at all.
	function automatic void retry_or_fail(input logic [2:0] st);
		p_count = '0;
		p_sum = '0;
		if (p_retries <= 8'd1) begin
			p_retries = '0;
			p_phase = PH_DONE;
			put_result(1'b0, CH_NONE, 1'b0, '0, '0, st, 1'b1);
		end else begin
			p_retries = p_retries - 8'd1;
			put_result(1'b1, CH_NAK, 1'b0, '0, '0, ST_PROGRESS, 1'b1);
		end
	endfunction

	// Advances the predictor by one accepted input beat and leaves the
	// results it causes in step_results.
	function automatic void xfer_advance(input logic [1:0] c, input logic [7:0] d);
		logic [7:0]  pair;
		logic [31:0] word;
		logic        lst;
		step_results.delete();
		// A start restarts the transfer from any phase.
		if (c == CMD_START) begin
			p_phase = PH_RECV;
			p_expect_seq = 8'd1;
			p_next_addr = c_base;
			p_retries = c_retry;
			p_seen = 1'b0;
			p_count = '0;
			p_sum = '0;
			put_result(1'b1, CH_NAK, 1'b0, '0, '0, ST_PROGRESS, 1'b1);
			return;
		end
		if (p_phase != PH_RECV || c == CMD_UNUSED)
			return;
		if (c == CMD_TIMEOUT) begin
			// Before any byte of the packet a timeout is just a prod for the
			// sender and costs nothing.
			if (!p_seen) begin
				p_count = '0;
				p_sum = '0;
				put_result(1'b1, CH_NAK, 1'b0, '0, '0, ST_PROGRESS, 1'b1);
			end else begin
				retry_or_fail(ST_TIMEOUT_FAIL);
			end
			return;
		end
		if (p_count == 8'd0) begin
			if (d == CH_EOT) begin
				p_phase = PH_DONE;
				put_result(1'b1, CH_ACK, 1'b0, '0, '0, ST_COMPLETED, 1'b1);
				return;
			end
			p_seen = 1'b1;
			p_hdr = d;
			p_sum = '0;
			p_count = 8'd1;
			return;
		end
		if (p_count == 8'd1) begin
			p_seq = d;
			p_count = 8'd2;
			return;
		end
		if (p_count == 8'd2) begin
			p_cpl = d;
			p_count = 8'd3;
			return;
		end
		if (p_count < SUM_BYTE_IDX) begin
			p_payload[PAYLOAD_IDX_W'(p_count - HDR_BYTES)] = d;
			p_sum = p_sum + d;
			p_count = p_count + 8'd1;
			return;
		end
		// The checksum byte closes the packet. The frame is checked first,
		// then the duplicate case (whose sum is never looked at), then the
		// number, then the sum.
		pair = p_seq + p_cpl;
		if (p_hdr != CH_SOH || pair != SEQ_PAIR_SUM) begin
			retry_or_fail(ST_SEQ_FAIL);
			return;
		end
		if (p_seq == 8'(p_expect_seq - 8'd1)) begin
			p_count = '0;
			p_sum = '0;
			put_result(1'b1, CH_ACK, 1'b0, '0, '0, ST_PROGRESS, 1'b1);
			return;
		end
		if (p_seq != p_expect_seq) begin
			retry_or_fail(ST_SEQ_FAIL);
			return;
		end
		if (p_sum != d) begin
			retry_or_fail(ST_SUM_FAIL);
			return;
		end
		// Good packet: 32 little-endian words, ACK riding on the last one.
		for (int k = 0; k < WORD_COUNT; k++) begin
			word = {p_payload[4*k+3], p_payload[4*k+2], p_payload[4*k+1], p_payload[4*k]};
			lst = (k == WORD_COUNT - 1);
			put_result(lst, lst ? CH_ACK : CH_NONE, 1'b1, p_next_addr + 32'(4 * k), word,
				ST_ACCEPTED, lst);
		end
		p_next_addr = p_next_addr + 32'(PAYLOAD_BYTES);
		p_expect_seq = p_expect_seq + 8'd1;
		p_retries = c_retry;
		p_seen = 1'b0;
		p_count = '0;
		p_sum = '0;
	endfunction

	// Offers one input beat, holds it until it is taken, then records what
	// the receiver owes for it.
	task automatic send_beat(input logic [1:0] c, input logic [7:0] d, input exp_how_t how);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		phase_items++;
		xfer_advance(c, d);
		case (how)
			EXP_PREDICT: begin
				foreach (step_results[i])
					awaited_results.push_back(step_results[i]);
			end
			EXP_NAK: begin
				awaited_results.push_back(xfer_result_t'{1'b1, CH_NAK, 1'b0, 32'd0, 32'd0,
					ST_PROGRESS, 1'b1});
			end
			EXP_DONE: begin
				awaited_results.push_back(xfer_result_t'{1'b1, CH_ACK, 1'b0, 32'd0, 32'd0,
					ST_COMPLETED, 1'b1});
			end
			default: begin
			end
		endcase
	endtask

	// Builds a packet for the given sequence number, spoils it as asked and
	// sends its first nbytes bytes.
	task automatic send_packet(input logic [7:0] seq, input flaw_t flaw, input fill_t fill,
			input int nbytes);
		logic [7:0] pkt [PACKET_BYTES];
		logic [7:0] sum;
		logic [7:0] b;
		sum = '0;
		pkt[0] = CH_SOH;
		if (flaw == FL_HEADER) begin
			// A bad header must not be an EOT, which would end the transfer.
			pkt[0] = 8'($urandom);
			if (pkt[0] == CH_SOH || pkt[0] == CH_EOT)
				pkt[0] = pkt[0] ^ 8'h80;
		end
		pkt[1] = seq;
		pkt[2] = ~seq;
		if (flaw == FL_COMPL)
			pkt[2] = pkt[2] ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			pkt[HDR_BYTES + i] = b;
			sum = sum + b;
		end
		pkt[SUM_BYTE_IDX] = (flaw == FL_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
		for (int i = 0; i < nbytes; i++)
			send_beat(CMD_BYTE, pkt[i], EXP_PREDICT);
	endtask

	// Drops the input valid and waits until every awaited result is out and
	// the block has had time to finish a byte that gives no result.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [31:0] val);
		quiesce();
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == CFG_BASE_ADDRESS)
			c_base = val;
		else
			c_retry = val[7:0];
		@(posedge clk);
	endtask

	function automatic plan_row_t beat_row(input logic [1:0] c, input logic [7:0] d,
			input exp_how_t how);
		plan_row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.c = c;
		r.d = d;
		r.how = how;
		return r;
	endfunction

	function automatic plan_row_t packet_row(input logic [7:0] seq, input flaw_t flaw,
			input fill_t fill, input int nbytes);
		plan_row_t r;
		r = '0;
		r.kind = ROW_PACKET;
		r.seq = seq;
		r.flaw = flaw;
		r.fill = fill;
		r.nbytes = 8'(nbytes);
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic idx, input logic [31:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// One random step of a transfer, chosen from the predictor's view of the
	// receiver. Steps are short: packets cut off by timeouts, bare timeouts,
	// end of transfer, restarts and noise.
	task automatic random_step();
		int    r;
		fill_t fill;
		r = $urandom_range(99);
		fill = (r < 3) ? FILL_ZERO : (r < 6) ? FILL_ONES : FILL_RANDOM;
		if (p_phase != PH_RECV) begin
			// Idle or finished: an occasional ignored beat, then a new transfer.
			if (r < 20)
				send_beat(2'($urandom_range(1, 3)), 8'($urandom), EXP_PREDICT);
			send_beat(CMD_START, 8'($urandom), EXP_PREDICT);
		end else if (r < 35) begin
			send_packet(p_expect_seq, FL_NONE, fill, $urandom_range(1, 8));
			send_beat(CMD_TIMEOUT, 8'($urandom), EXP_PREDICT);
		end else if (r < 55) begin
			send_beat(CMD_TIMEOUT, 8'($urandom), EXP_PREDICT);
		end else if (r < 65) begin
			send_beat(CMD_BYTE, CH_EOT, EXP_PREDICT);
		end else if (r < 75) begin
			send_beat(CMD_START, 8'($urandom), EXP_PREDICT);
		end else if (r < 90) begin
			send_beat(CMD_BYTE, 8'($urandom), EXP_PREDICT);
			send_beat(CMD_TIMEOUT, 8'($urandom), EXP_PREDICT);
		end else begin
			send_beat(CMD_UNUSED, 8'($urandom), EXP_PREDICT);
		end
	endtask

	// The receiver side stalls at random with the probability of the phase.
	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	// Every accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		xfer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result at write_address", write_address, '0);
			end else begin
				want = awaited_results.pop_front();
				if (reply_valid !== want.reply_v)
					flag_mismatch("reply_valid", 32'(reply_valid), 32'(want.reply_v));
				if (reply_byte !== want.reply_b)
					flag_mismatch("reply_byte", 32'(reply_byte), 32'(want.reply_b));
				if (write_valid !== want.wr_v)
					flag_mismatch("write_valid", 32'(write_valid), 32'(want.wr_v));
				if (write_address !== want.wr_addr)
					flag_mismatch("write_address", write_address, want.wr_addr);
				if (write_word !== want.wr_word)
					flag_mismatch("write_word", write_word, want.wr_word);
				if (status !== want.stat)
					flag_mismatch("status", 32'(status), 32'(want.stat));
				if (last !== want.lst)
					flag_mismatch("last", 32'(last), 32'(want.lst));
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no beat on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		// Predictor starts from the reset state of the block.
		p_phase = PH_IDLE;
		p_count = '0;
		p_expect_seq = 8'd1;
		p_retries = '0;
		p_seen = 1'b0;
		p_hdr = '0;
		p_seq = '0;
		p_cpl = '0;
		p_sum = '0;
		p_next_addr = '0;
		c_base = '0;
		c_retry = RETRY_LIMIT_RESET;

		// Events before any start are ignored, including the unused command.
		plan.push_back(beat_row(CMD_BYTE, CH_SOH, EXP_NONE));
		plan.push_back(beat_row(CMD_TIMEOUT, 8'h00, EXP_NONE));
		plan.push_back(beat_row(CMD_UNUSED, 8'hFF, EXP_NONE));
		// A base close to the top: the flash addresses of the block wrap
		// halfway through. Two retries per packet.
		plan.push_back(reg_row(CFG_BASE_ADDRESS, 32'hFFFF_FFC0));
		plan.push_back(reg_row(CFG_RETRY_LIMIT, 32'd2));
		// Start, and a timeout before any byte, both answer with NAK.
		plan.push_back(beat_row(CMD_START, 8'hA5, EXP_NAK));
		plan.push_back(beat_row(CMD_TIMEOUT, 8'h5A, EXP_NAK));
		plan.push_back(packet_row(8'd1, FL_NONE, FILL_RANDOM, PACKET_BYTES));
		// A timeout inside a packet drops it and costs a retry; the next one
		// still counts as after the first byte and fails the transfer.
		plan.push_back(packet_row(8'd2, FL_NONE, FILL_RANDOM, 10));
		plan.push_back(beat_row(CMD_TIMEOUT, 8'h00, EXP_NAK));
		plan.push_back(beat_row(CMD_TIMEOUT, 8'hFF, EXP_PREDICT));
		plan.push_back(beat_row(CMD_BYTE, 8'hFF, EXP_NONE));
		// A start after a failure, then the end of the transfer.
		plan.push_back(beat_row(CMD_START, 8'h00, EXP_NAK));
		plan.push_back(beat_row(CMD_BYTE, CH_EOT, EXP_DONE));
		// A start in the middle of a packet throws it away.
		plan.push_back(beat_row(CMD_START, 8'h00, EXP_NAK));
		plan.push_back(packet_row(8'd1, FL_NONE, FILL_RANDOM, 20));
		plan.push_back(beat_row(CMD_START, 8'h00, EXP_NAK));
		plan.push_back(reg_row(CFG_RETRY_LIMIT, 32'd255));
		plan.push_back(reg_row(CFG_BASE_ADDRESS, 32'd0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run with light idling on both sides.
		idle_pct = 9;
		stall_pct = 9;
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_BEAT: send_beat(plan[i].c, plan[i].d, plan[i].how);
				ROW_PACKET: send_packet(plan[i].seq, plan[i].flaw, plan[i].fill,
					plan[i].nbytes);
				default: set_reg(plan[i].reg_idx, plan[i].reg_val);
			endcase
		end

		// Random steps under each idling profile, with new registers at the
		// start of each phase.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 88;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 88;
				end
				default: begin
					idle_pct = 9;
					stall_pct = 9;
				end
			endcase
			set_reg(CFG_BASE_ADDRESS, (ph == 0) ? 32'hFFFF_FFF0 : 32'($urandom));
			case (ph)
				0: set_reg(CFG_RETRY_LIMIT, 32'd255);
				1: set_reg(CFG_RETRY_LIMIT, 32'd2);
				2: set_reg(CFG_RETRY_LIMIT, 32'd3);
				default: set_reg(CFG_RETRY_LIMIT, 32'($urandom_range(1, 4)));
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_step();
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
